// ===== rtl/count_stream_log_rle_binner_assert.svh =====
// ----------------------------------------------------------------------------
// count stream log rle binner - assertion macros
// immediate-consequence and next-cycle property forms, clocked and reset-gated
// ----------------------------------------------------------------------------
`ifndef COUNT_STREAM_LOG_RLE_BINNER_ASSERT_SVH
`define COUNT_STREAM_LOG_RLE_BINNER_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define CRB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequence must hold in the cycle after the antecedent
`define CRB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_pkg
// shared types, constants and helper functions of the count stream binner
// ----------------------------------------------------------------------------
package crb_pkg;

    localparam int COUNT_WIDTH     = 32;
    localparam int BIN_WIDTH       = 16;
    localparam int RUN_WIDTH       = 32;
    localparam int SUM_WIDTH       = 64;
    localparam int CLASS_WIDTH     = 7;
    localparam int CLASS_OFFSET    = 33;
    localparam int CLASS_MAX       = CLASS_OFFSET + RUN_WIDTH;
    localparam int FX_WIDTH        = 40;
    localparam int FRAC_BITS       = 9;
    localparam int QUOT_WIDTH      = SUM_WIDTH + FRAC_BITS;
    localparam int STEP_WIDTH      = $clog2(QUOT_WIDTH);
    localparam int MODE_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = (BIN_WIDTH > MODE_WIDTH) ? BIN_WIDTH : MODE_WIDTH;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);

    // operating modes (code 3 behaves as whole mode)
    localparam logic [MODE_WIDTH-1:0] MODE_BIN   = 2'd0;
    localparam logic [MODE_WIDTH-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_WIDTH-1:0] MODE_WHOLE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BIN_SIZE = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ASCII    = 2'd2;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] kmer_count;
        logic                   end_of_sequence;
    } in_item_t;

    typedef struct packed {
        logic [CLASS_WIDTH-1:0] score_class;
        logic [RUN_WIDTH-1:0]   run_length;
        logic [FX_WIDTH-1:0]    average_fixed;
        logic [RUN_WIDTH-1:0]   average_rounded;
        logic                   report_class;
        logic                   last_of_sequence;
    } out_item_t;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic [BIN_WIDTH-1:0]  bin_size;
        logic                  ascii_mode;
    } cfg_t;

    // one unit of work handed from front to back
    typedef struct packed {
        logic                   is_avg;
        logic [CLASS_WIDTH-1:0] cls;
        logic [RUN_WIDTH-1:0]   len;
        logic [SUM_WIDTH-1:0]   sum;
        logic                   report;
        logic                   last;
    } job_t;

    typedef struct packed {
        logic empty;
        logic two_free;
    } fifo_stat_t;

    // bit length plus class offset
    function automatic logic [CLASS_WIDTH-1:0] log_class(input logic [RUN_WIDTH-1:0] v);
        logic [CLASS_WIDTH-1:0] n;
        n = '0;
        for (int i = 0; i < RUN_WIDTH; i++) begin
            if (v[i]) begin
                n = CLASS_WIDTH'(i + 1);
            end
        end
        return n + CLASS_WIDTH'(CLASS_OFFSET);
    endfunction

    function automatic job_t make_job(input logic                   is_avg,
                                      input logic [CLASS_WIDTH-1:0] cls,
                                      input logic [RUN_WIDTH-1:0]   len,
                                      input logic [SUM_WIDTH-1:0]   sum,
                                      input logic                   report,
                                      input logic                   last);
        job_t j;
        j.is_avg = is_avg;
        j.cls    = cls;
        j.len    = len;
        j.sum    = sum;
        j.report = report;
        j.last   = last;
        return j;
    endfunction

endpackage

// ===== rtl/crb_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_fifo
// short job queue between the classifying front and the computing back
// ----------------------------------------------------------------------------
module crb_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  crb_pkg::job_t       push_job,
    input  logic                pop,
    output crb_pkg::job_t       head_job,
    output crb_pkg::fifo_stat_t stat
);

    crb_pkg::job_t                        mem_reg [crb_pkg::FIFO_DEPTH];
    logic [crb_pkg::FIFO_PTR_WIDTH-1:0]   wr_ptr_reg;
    logic [crb_pkg::FIFO_PTR_WIDTH-1:0]   rd_ptr_reg;
    logic [crb_pkg::FIFO_PTR_WIDTH:0]     count_reg;

    assign head_job      = mem_reg[rd_ptr_reg];
    assign stat.empty    = (count_reg == '0);
    assign stat.two_free = (count_reg <= (crb_pkg::FIFO_PTR_WIDTH + 1)'(crb_pkg::FIFO_DEPTH - 2));

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/crb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_div
// bit-serial restoring divider, sum scaled by 2^9 over item count
// ----------------------------------------------------------------------------
module crb_div (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [crb_pkg::SUM_WIDTH-1:0]     dividend,
    input  logic [crb_pkg::RUN_WIDTH-1:0]     divisor,
    output logic                              done,
    output logic [crb_pkg::QUOT_WIDTH-1:0]    quot
);

    logic [crb_pkg::QUOT_WIDTH-1:0] dq_reg;
    logic [crb_pkg::RUN_WIDTH-1:0]  rem_reg;
    logic [crb_pkg::RUN_WIDTH-1:0]  dvs_reg;
    logic [crb_pkg::STEP_WIDTH-1:0] step_reg;
    logic                           busy_reg;

    logic [crb_pkg::RUN_WIDTH:0]    rem_sh;
    logic [crb_pkg::RUN_WIDTH:0]    diff;
    logic                           ge;

    assign rem_sh = {rem_reg, dq_reg[crb_pkg::QUOT_WIDTH-1]};
    assign diff   = rem_sh - {1'b0, dvs_reg};
    assign ge     = (rem_sh >= {1'b0, dvs_reg});
    assign done   = busy_reg && (step_reg == crb_pkg::STEP_WIDTH'(crb_pkg::QUOT_WIDTH - 1));
    assign quot   = dq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            dq_reg   <= {dividend, crb_pkg::FRAC_BITS'(0)};
            rem_reg  <= '0;
            // zero count never reaches here, treat as one anyway
            dvs_reg  <= (divisor == '0) ? crb_pkg::RUN_WIDTH'(1) : divisor;
            step_reg <= '0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            rem_reg  <= ge ? diff[crb_pkg::RUN_WIDTH-1:0] : rem_sh[crb_pkg::RUN_WIDTH-1:0];
            dq_reg   <= {dq_reg[crb_pkg::QUOT_WIDTH-2:0], ge};
            step_reg <= step_reg + 1'b1;
            if (done) begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/crb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_front
// accepts counts, tracks run / bin state and queues result jobs
// ----------------------------------------------------------------------------
module crb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  crb_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  crb_pkg::in_item_t   s_data,
    input  crb_pkg::fifo_stat_t fifo_stat,
    output logic                push,
    output crb_pkg::job_t       push_job
);

    logic [crb_pkg::CLASS_WIDTH-1:0] cls_reg, cls_next;
    logic [crb_pkg::RUN_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [crb_pkg::SUM_WIDTH-1:0]   sum_reg, sum_next;
    logic                            pend_valid_reg;
    crb_pkg::job_t                   pend_job_reg;

    logic [crb_pkg::RUN_WIDTH-1:0]   count_w;
    logic [crb_pkg::CLASS_WIDTH-1:0] cls_new;
    logic [crb_pkg::RUN_WIDTH-1:0]   cnt_inc;
    logic [crb_pkg::SUM_WIDTH:0]     sum_wide;
    logic [crb_pkg::SUM_WIDTH-1:0]   sum_inc;
    logic [crb_pkg::RUN_WIDTH-1:0]   size_eff;
    logic                            eos;
    logic                            accept;
    logic                            v0, v1;
    crb_pkg::job_t                   job0, job1;

    assign s_ready  = !pend_valid_reg && fifo_stat.two_free;
    assign accept   = s_valid && s_ready;
    assign push     = pend_valid_reg || (accept && v0);
    assign push_job = pend_valid_reg ? pend_job_reg : job0;

    always_comb begin
        count_w  = crb_pkg::RUN_WIDTH'(s_data.kmer_count);
        eos      = s_data.end_of_sequence;
        cls_new  = crb_pkg::log_class(count_w);
        cnt_inc  = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        sum_wide = {1'b0, sum_reg} + (crb_pkg::SUM_WIDTH + 1)'(count_w);
        sum_inc  = sum_wide[crb_pkg::SUM_WIDTH] ? '1 : sum_wide[crb_pkg::SUM_WIDTH-1:0];
        size_eff = (cfg.bin_size == '0) ? crb_pkg::RUN_WIDTH'(1)
                                        : crb_pkg::RUN_WIDTH'(cfg.bin_size);
        cls_next = cls_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        v0       = 1'b0;
        v1       = 1'b0;
        job0     = '0;
        job1     = '0;

        if (cfg.mode == crb_pkg::MODE_RUN) begin
            if (cls_reg == cls_new) begin
                cnt_next = cnt_inc;
            end else begin
                // class change closes the open run
                if (cls_reg != '0) begin
                    v0   = 1'b1;
                    job0 = crb_pkg::make_job(1'b0, cls_reg, cnt_reg, '0, cfg.ascii_mode, 1'b0);
                end
                cls_next = cls_new;
                cnt_next = crb_pkg::RUN_WIDTH'(1);
            end
            if (eos) begin
                if (v0) begin
                    v1   = 1'b1;
                    job1 = crb_pkg::make_job(1'b0, cls_next, cnt_next, '0, cfg.ascii_mode, 1'b1);
                end else begin
                    v0   = 1'b1;
                    job0 = crb_pkg::make_job(1'b0, cls_next, cnt_next, '0, cfg.ascii_mode, 1'b1);
                end
                cls_next = '0;
                cnt_next = '0;
                sum_next = '0;
            end
        end else begin
            sum_next = sum_inc;
            cnt_next = cnt_inc;
            if (eos || ((cfg.mode == crb_pkg::MODE_BIN) && (cnt_inc >= size_eff))) begin
                v0       = 1'b1;
                job0     = crb_pkg::make_job(1'b1, '0, cnt_inc, sum_inc, cfg.ascii_mode, eos);
                cls_next = '0;
                cnt_next = '0;
                sum_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cls_reg        <= '0;
            cnt_reg        <= '0;
            sum_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                cls_reg <= cls_next;
                cnt_reg <= cnt_next;
                sum_reg <= sum_next;
            end
            if (accept && v1) begin
                pend_valid_reg <= 1'b1;
                pend_job_reg   <= job1;
            end else if (pend_valid_reg) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/crb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_back
// pops jobs, divides for averages, rounds and drives the result register
// ----------------------------------------------------------------------------
module crb_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  crb_pkg::fifo_stat_t fifo_stat,
    input  crb_pkg::job_t       head_job,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output crb_pkg::out_item_t  m_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN, ST_OUT} state_t;

    state_t                           state_reg;
    crb_pkg::job_t                    job_reg;
    logic [crb_pkg::FX_WIDTH-1:0]     fx_reg;
    logic [crb_pkg::RUN_WIDTH-1:0]    rd_reg;
    logic                             m_valid_reg;
    crb_pkg::out_item_t               m_data_reg;

    logic                             div_done;
    logic [crb_pkg::QUOT_WIDTH-1:0]   quot;
    logic [crb_pkg::SUM_WIDTH-1:0]    q_int;
    logic                             over;
    logic [crb_pkg::FX_WIDTH+1:0]     fx_sum;
    logic [crb_pkg::RUN_WIDTH:0]      rd_sum;
    logic [crb_pkg::FX_WIDTH-1:0]     fx_sat;
    logic [crb_pkg::RUN_WIDTH-1:0]    rd_sat;
    logic                             out_free;

    assign pop      = (state_reg == ST_IDLE) && !fifo_stat.empty;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    crb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (pop && head_job.is_avg),
        .dividend (head_job.sum),
        .divisor  (head_job.len),
        .done     (div_done),
        .quot     (quot)
    );

    // quot = floor(sum * 512 / n); fixed average is (quot + 1) >> 1
    always_comb begin
        q_int  = quot[crb_pkg::QUOT_WIDTH-1:crb_pkg::FRAC_BITS];
        over   = |q_int[crb_pkg::SUM_WIDTH-1:crb_pkg::RUN_WIDTH];
        fx_sum = {1'b0, quot[crb_pkg::FX_WIDTH:0]} + (crb_pkg::FX_WIDTH + 2)'(1);
        rd_sum = {1'b0, q_int[crb_pkg::RUN_WIDTH-1:0]}
               + (crb_pkg::RUN_WIDTH + 1)'(quot[crb_pkg::FRAC_BITS-1]);
        fx_sat = (over || fx_sum[crb_pkg::FX_WIDTH+1]) ? '1 : fx_sum[crb_pkg::FX_WIDTH:1];
        rd_sat = (over || rd_sum[crb_pkg::RUN_WIDTH]) ? '1 : rd_sum[crb_pkg::RUN_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // load a new result or drop the one just taken
            if ((state_reg == ST_OUT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (!fifo_stat.empty) begin
                        job_reg <= head_job;
                        if (head_job.is_avg) begin
                            state_reg <= ST_DIV;
                        end else begin
                            fx_reg    <= '0;
                            rd_reg    <= '0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    fx_reg    <= fx_sat;
                    rd_reg    <= rd_sat;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_data_reg.score_class      <= job_reg.is_avg
                                                       ? crb_pkg::log_class(rd_reg)
                                                       : job_reg.cls;
                        m_data_reg.run_length       <= job_reg.len;
                        m_data_reg.average_fixed    <= fx_reg;
                        m_data_reg.average_rounded  <= rd_reg;
                        m_data_reg.report_class     <= job_reg.report;
                        m_data_reg.last_of_sequence <= job_reg.last;
                        state_reg                   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/count_stream_log_rle_binner.sv =====
`timescale 1ns / 1ps
// a run result passes the job queue and the back's idle and output states into
//   the result register; averages add the divider and the finish state.
//   One input transfer per cycle while no second end-of-sequence job is held
//   and the job queue has two free slots; the back takes one job at a time.
// reset: synchronous active-low aresetn clears run/bin state, queue and result
//   valid flag; config returns to bin mode, bin_size 1, ascii_mode 0
// ----------------------------------------------------------------------------
// count_stream_log_rle_binner
// run-length coder of log classes and bin / whole-sequence averager of counts
// ----------------------------------------------------------------------------
module count_stream_log_rle_binner (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // count stream in
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  crb_pkg::in_item_t                      s_data,
    // result stream out
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output crb_pkg::out_item_t                     m_data,
    // register writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [crb_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [crb_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

    crb_pkg::cfg_t       cfg_reg;
    crb_pkg::fifo_stat_t fifo_stat;
    crb_pkg::job_t       push_job;
    crb_pkg::job_t       head_job;
    logic                push;
    logic                pop;

    // register writes always complete in one transfer; they never touch
    // the run / bin state, so a mode change inherits whatever is open
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= crb_pkg::MODE_BIN;
            cfg_reg.bin_size   <= crb_pkg::BIN_WIDTH'(1);
            cfg_reg.ascii_mode <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                crb_pkg::CFG_MODE: begin
                    cfg_reg.mode <= cfg_data[crb_pkg::MODE_WIDTH-1:0];
                end
                crb_pkg::CFG_BIN_SIZE: begin
                    cfg_reg.bin_size <= cfg_data[crb_pkg::BIN_WIDTH-1:0];
                end
                crb_pkg::CFG_ASCII: begin
                    cfg_reg.ascii_mode <= cfg_data[0];
                end
                default: begin
                    // unmapped index, write dropped
                end
            endcase
        end
    end

    // front: classify each count, update the open run or bin, emit jobs
    crb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_job  (push_job)
    );

    // queue decouples the front from the long divide in the back
    crb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (fifo_stat)
    );

    // back: divide, round, saturate and hold the result for the sink
    crb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fifo_stat (fifo_stat),
        .head_job  (head_job),
        .pop       (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== rtl/crb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crb_checker
// port-level checks on the result stream of the count stream binner
// ----------------------------------------------------------------------------
`include "count_stream_log_rle_binner_assert.svh"

module crb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input crb_pkg::out_item_t m_data
);

    logic stall;
    logic class_ok;
    logic len_ok;
    logic round_ok;

    assign stall    = m_valid && !m_ready;
    assign class_ok = (m_data.score_class >= crb_pkg::CLASS_WIDTH'(crb_pkg::CLASS_OFFSET))
                   && (m_data.score_class <= crb_pkg::CLASS_WIDTH'(crb_pkg::CLASS_MAX));
    assign len_ok   = (m_data.run_length != '0);
    assign round_ok = (m_data.average_fixed[39:8] <= m_data.average_rounded);

    // a stalled result holds
    `CRB_ASSERT_NEXT(a_out_hold, aclk, aresetn, stall, m_valid && $stable(m_data), "result moved")

    // every class is a bit length plus the offset
    `CRB_ASSERT_NOW(a_class_range, aclk, aresetn, m_valid, class_ok, "score class out of range")

    // runs and bins always hold at least one item
    `CRB_ASSERT_NOW(a_len_nonzero, aclk, aresetn, m_valid, len_ok, "empty run or bin reported")

    // integer part of the fixed average never passes the rounded average
    `CRB_ASSERT_NOW(a_round_order, aclk, aresetn, m_valid, round_ok, "averages disagree")

endmodule

bind count_stream_log_rle_binner crb_checker u_crb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
